// ===== hdl/varint_length_string_deframer_top_macros.svh =====
// assertion macros shared by the deframer checker
`ifndef VARINT_LENGTH_STRING_DEFRAMER_TOP_MACROS_SVH
`define VARINT_LENGTH_STRING_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VLSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define VLSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vlsd_pkg.sv =====
// shared types and constants of the length-prefixed string deframer
package vlsd_pkg;

    localparam int         GROUP_BITS  = 7;
    localparam logic [7:0] GROUP_MASK  = 8'h7F;
    localparam logic [7:0] CONT_FLAG   = 8'h80;
    localparam int         GROUP_CNT_W = 4;
    localparam int         COUNT_W     = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_PAYLOAD     = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_PREFIX_CUT  = 3'd2,
        ST_PREFIX_BIG  = 3'd3,
        ST_NO_ROOM     = 3'd4,
        ST_PAYLOAD_CUT = 3'd5
    } status_t;

    typedef enum logic {
        PH_PREFIX  = 1'b0,
        PH_PAYLOAD = 1'b1
    } phase_t;

    typedef struct packed {
        logic len_zero;
        logic over_room;
        logic group_limit;
    } prefix_flags_t;

endpackage

// ===== hdl/vlsd_if.sv =====
// word channels of the deframer: input bytes, results and configuration writes
interface vlsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface vlsd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic        is_last;
    logic [31:0] bytes_consumed;

    modport source (output valid, output out_byte, output status, output is_last,
                    output bytes_consumed, input ready);
    modport sink   (input valid, input out_byte, input status, input is_last,
                    input bytes_consumed, output ready);
endinterface

interface vlsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] free_space;

    modport source (output valid, output free_space, input ready);
    modport sink   (input valid, input free_space, output ready);
endinterface

// ===== hdl/vlsd_prefix.sv =====
// prefix group accumulate and length checks against free space
module vlsd_prefix #(
    parameter int LEN_BITS = 32
) (
    input  logic [LEN_BITS-1:0]             accum,
    input  logic [vlsd_pkg::GROUP_CNT_W-1:0] group_count,
    input  logic [7:0]                      data_byte,
    input  logic [31:0]                     free_space,
    output logic [LEN_BITS-1:0]             accum_next,
    output logic [31:0]                     length_low,
    output vlsd_pkg::prefix_flags_t         flags
);

    localparam int GROUP_MAX = (LEN_BITS + vlsd_pkg::GROUP_BITS - 1) / vlsd_pkg::GROUP_BITS;
    localparam int SHIFT_W   = $clog2(vlsd_pkg::GROUP_BITS * GROUP_MAX);
    localparam int CMP_W     = (LEN_BITS > 32) ? LEN_BITS : 32;

    logic [SHIFT_W-1:0]  shift_amt;
    logic [LEN_BITS-1:0] group_val;
    logic                group_ok;
    logic [CMP_W-1:0]    accum_ext;

    always_comb
    begin
        shift_amt  = SHIFT_W'(group_count * vlsd_pkg::GROUP_BITS);
        group_ok   = (group_count < vlsd_pkg::GROUP_CNT_W'(GROUP_MAX));
        // bits shifted past the top are dropped by the width
        group_val  = LEN_BITS'(data_byte & vlsd_pkg::GROUP_MASK) << shift_amt;
        accum_next = accum | (group_ok ? group_val : '0);
        accum_ext  = CMP_W'(accum_next);
        length_low = accum_ext[31:0];

        flags.len_zero    = (accum_next == '0);
        flags.over_room   = (accum_ext > CMP_W'(free_space));
        flags.group_limit = (group_count >= vlsd_pkg::GROUP_CNT_W'(GROUP_MAX - 1));
    end

endmodule

// ===== hdl/varint_length_string_deframer_top.sv =====
// top level of the length-prefixed string deframer
// takes one byte word per cycle, back to back, and gives at most one result word per
// input word; each string opens with a little-endian base-128 length prefix (7 bits
// per byte, bit 7 = more follows, at most ceil(LEN_BITS/7) bytes, length bits at or
// above LEN_BITS dropped); its payload bytes then pass through, the last one flagged
// with is_last and the count of prefix plus payload bytes taken (saturating at
// 0xFFFFFFFF); an empty string gives one status-1 word; errors (buffer end in prefix,
// prefix too large, length above free_space, buffer end in payload) give one word with
// is_last set; every word goes through an input register and then the result register,
// which loads only while it is empty or its word is being taken; ready is held low only
// when both registers are full and the result side is stalling; free_space is written
// through cfg_ch, always ready, and is the value compared by prefixes that end after
// the write
module varint_length_string_deframer_top #(
    parameter int LEN_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    vlsd_in_if.sink   bytes_ch,
    vlsd_out_if.source result_ch,
    vlsd_cfg_if.sink  cfg_ch
);

    // configuration register
    logic [31:0] free_space_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;

    // deframing state
    vlsd_pkg::phase_t                 phase_reg, phase_next;
    logic [vlsd_pkg::GROUP_CNT_W-1:0] group_count_reg, group_count_next;
    logic [LEN_BITS-1:0]              accum_reg, accum_next;
    logic [31:0]                      remaining_reg, remaining_next;
    logic [vlsd_pkg::COUNT_W-1:0]     consumed_reg, consumed_next;

    // result register
    logic                             out_valid_reg;
    logic [7:0]                       out_byte_reg, out_byte_next;
    vlsd_pkg::status_t                out_status_reg, out_status_next;
    logic                             out_last_reg, out_last_next;
    logic [vlsd_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    logic                             out_free;
    logic                             fire;
    logic                             emit;
    logic                             restart;
    logic                             cont;
    logic [LEN_BITS-1:0]              accum_calc;
    logic [31:0]                      length_low;
    logic [31:0]                      remaining_dec;
    logic [vlsd_pkg::COUNT_W-1:0]     count_inc;
    vlsd_pkg::prefix_flags_t          flags;

    // handshakes: the input register moves on whenever the result register can load
    assign out_free       = !out_valid_reg || result_ch.ready;
    assign fire           = in_valid_reg && out_free;
    assign bytes_ch.ready = !in_valid_reg || out_free;
    assign cfg_ch.ready   = 1'b1;

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.out_byte       = out_byte_reg;
    assign result_ch.status         = out_status_reg;
    assign result_ch.is_last        = out_last_reg;
    assign result_ch.bytes_consumed = out_count_reg;

    vlsd_prefix #(
        .LEN_BITS (LEN_BITS)
    ) u_prefix (
        .accum       (accum_reg),
        .group_count (group_count_reg),
        .data_byte   (in_byte_reg),
        .free_space  (free_space_reg),
        .accum_next  (accum_calc),
        .length_low  (length_low),
        .flags       (flags)
    );

    always_comb
    begin
        cont          = |(in_byte_reg & vlsd_pkg::CONT_FLAG);
        count_inc     = (consumed_reg == vlsd_pkg::COUNT_MAX) ? consumed_reg
                                                              : consumed_reg + 1'b1;
        remaining_dec = remaining_reg - 32'd1;

        phase_next       = phase_reg;
        group_count_next = group_count_reg;
        accum_next       = accum_reg;
        remaining_next   = remaining_reg;
        consumed_next    = consumed_reg;

        emit            = 1'b0;
        restart         = 1'b0;
        out_byte_next   = 8'd0;
        out_status_next = vlsd_pkg::ST_PAYLOAD;
        out_last_next   = 1'b0;
        out_count_next  = '0;

        case (phase_reg)
            vlsd_pkg::PH_PREFIX:
            begin
                if (in_eob_reg)
                begin
                    emit            = 1'b1;
                    restart         = 1'b1;
                    out_status_next = vlsd_pkg::ST_PREFIX_CUT;
                    out_last_next   = 1'b1;
                    out_count_next  = consumed_reg;
                end
                else
                begin
                    accum_next       = accum_calc;
                    group_count_next = group_count_reg + 1'b1;
                    consumed_next    = count_inc;
                    if (cont)
                    begin
                        // last allowed group still asks for more
                        if (flags.group_limit)
                        begin
                            emit            = 1'b1;
                            restart         = 1'b1;
                            out_status_next = vlsd_pkg::ST_PREFIX_BIG;
                            out_last_next   = 1'b1;
                            out_count_next  = count_inc;
                        end
                    end
                    else if (flags.len_zero)
                    begin
                        emit            = 1'b1;
                        restart         = 1'b1;
                        out_status_next = vlsd_pkg::ST_EMPTY;
                        out_last_next   = 1'b1;
                        out_count_next  = count_inc;
                    end
                    else if (flags.over_room)
                    begin
                        // payload is not skipped; next byte starts a new prefix
                        emit            = 1'b1;
                        restart         = 1'b1;
                        out_status_next = vlsd_pkg::ST_NO_ROOM;
                        out_last_next   = 1'b1;
                        out_count_next  = count_inc;
                    end
                    else
                    begin
                        remaining_next = length_low;
                        phase_next     = vlsd_pkg::PH_PAYLOAD;
                    end
                end
            end
            vlsd_pkg::PH_PAYLOAD:
            begin
                if (in_eob_reg)
                begin
                    emit            = 1'b1;
                    restart         = 1'b1;
                    out_status_next = vlsd_pkg::ST_PAYLOAD_CUT;
                    out_last_next   = 1'b1;
                    out_count_next  = consumed_reg;
                end
                else
                begin
                    emit            = 1'b1;
                    out_byte_next   = in_byte_reg;
                    out_status_next = vlsd_pkg::ST_PAYLOAD;
                    remaining_next  = remaining_dec;
                    consumed_next   = count_inc;
                    if (remaining_dec == 32'd0)
                    begin
                        restart        = 1'b1;
                        out_last_next  = 1'b1;
                        out_count_next = count_inc;
                    end
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        // back to reading a prefix after every finished string or error
        if (restart)
        begin
            phase_next       = vlsd_pkg::PH_PREFIX;
            group_count_next = '0;
            accum_next       = '0;
            remaining_next   = '0;
            consumed_next    = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_space_reg  <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= vlsd_pkg::PH_PREFIX;
            group_count_reg <= '0;
            accum_reg       <= '0;
            remaining_reg   <= '0;
            consumed_reg    <= '0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                free_space_reg <= cfg_ch.free_space;
            end
            if (bytes_ch.ready)
            begin
                in_valid_reg <= bytes_ch.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= fire && emit;
            end
            if (fire)
            begin
                phase_reg       <= phase_next;
                group_count_reg <= group_count_next;
                accum_reg       <= accum_next;
                remaining_reg   <= remaining_next;
                consumed_reg    <= consumed_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (bytes_ch.valid && bytes_ch.ready)
        begin
            in_byte_reg <= bytes_ch.data_byte;
            in_eob_reg  <= bytes_ch.end_of_buffer;
        end
        if (fire && emit)
        begin
            out_byte_reg   <= out_byte_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule

// ===== hdl/vlsd_checker.sv =====
// port-level checks on the deframer result channel, bound to the top level
`include "varint_length_string_deframer_top_macros.svh"

module vlsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic [2:0]  status,
    input logic        is_last,
    input logic [31:0] bytes_consumed
);

    // every non-payload word closes a string
    `VLSD_ASSERT_NOW(a_status_last, out_valid && (status != vlsd_pkg::ST_PAYLOAD), is_last, "non-payload word without is_last")

    // count only shown on the closing word
    `VLSD_ASSERT_NOW(a_count_zero, out_valid && !is_last, bytes_consumed == 32'd0, "count on a word that is not last")

    // byte field is zero unless a payload byte is carried
    `VLSD_ASSERT_NOW(a_byte_zero, out_valid && (status != vlsd_pkg::ST_PAYLOAD), out_byte == 8'd0, "byte on a status word")

    // a stalled result holds
    `VLSD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(status) && $stable(is_last) && $stable(bytes_consumed), "stalled result changed")

endmodule

bind varint_length_string_deframer_top vlsd_checker u_vlsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result_ch.valid),
    .out_ready      (result_ch.ready),
    .out_byte       (result_ch.out_byte),
    .status         (result_ch.status),
    .is_last        (result_ch.is_last),
    .bytes_consumed (result_ch.bytes_consumed)
);
